FILE: hdl/arpc_pkg.sv
// shared constants, codes and types of the arp cache table
package arpc_pkg;

    localparam int SLOTS      = 16;
    localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int IP_W       = 32;
    localparam int MAC_W      = 48;
    localparam int ENTRY_W    = IP_W + MAC_W;
    localparam int SLOT_OUT_W = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 48;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_UPDATE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_MISS    = 2'd1,
        ST_PRESENT = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HOST_IP  = 1'd0,
        REG_HOST_MAC = 1'd1
    } cfg_reg_t;

    typedef logic [SLOT_W-1:0] slot_t;

    // per-slot outcome of the shared comparator
    typedef struct packed {
        logic hit;
        logic free;
    } cmp_res_t;

    // slot number as reported, low bits only
    function automatic logic [SLOT_OUT_W-1:0] slot_report(slot_t s);
        logic [SLOT_W+SLOT_OUT_W-1:0] wide;
        begin
            wide = {{SLOT_OUT_W{1'b0}}, s};
            return wide[SLOT_OUT_W-1:0];
        end
    endfunction

endpackage

FILE: hdl/arpc_if.sv
// request and response channel interfaces of the arp cache table
interface arpc_req_if import arpc_pkg::*; ();
    logic             valid;
    logic             ready;
    op_t              operation;
    logic [IP_W-1:0]  ip_addr;
    logic [MAC_W-1:0] mac_addr;

    modport source (output valid, output operation, output ip_addr, output mac_addr,
                    input ready);
    modport sink   (input valid, input operation, input ip_addr, input mac_addr,
                    output ready);
endinterface

interface arpc_rsp_if import arpc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    status_t               status;
    logic [MAC_W-1:0]      mac_out;
    logic [SLOT_OUT_W-1:0] slot_out;

    modport source (output valid, output status, output mac_out, output slot_out,
                    input ready);
    modport sink   (input valid, input status, input mac_out, input slot_out,
                    output ready);
endinterface

FILE: hdl/arpc_ram.sv
// generic single-write, single-read ram with registered read data
module arpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

FILE: hdl/arpc_cmp.sv
// shared slot comparator: ip/mac match and free-slot test for one slot per cycle
module arpc_cmp import arpc_pkg::*; (
    input  op_t              op,
    input  logic [IP_W-1:0]  req_ip,
    input  logic [MAC_W-1:0] req_mac,
    input  logic [IP_W-1:0]  ent_ip,
    input  logic [MAC_W-1:0] ent_mac,
    input  logic             ent_valid,
    input  logic             ent_static,
    output cmp_res_t         res
);
    logic ip_eq;
    logic mac_eq;

    always_comb
    begin
        ip_eq  = (ent_ip == req_ip);
        mac_eq = (ent_mac == req_mac);
        // delete needs both fields and never touches the static slot
        if (op == OP_DELETE)
        begin
            res.hit = ent_valid && !ent_static && ip_eq && mac_eq;
        end
        else
        begin
            res.hit = ent_valid && ip_eq;
        end
        res.free = !ent_static && !ent_valid;
    end
endmodule

FILE: hdl/arp_cache_table_top.sv
// arp cache table: ipv4-to-mac cache with a static local entry in slot 0
//
// One request is taken at a time. After the request item is accepted the slot ram is
// read one slot per cycle and each slot goes through a single shared comparator, in
// slot order, stopping at the first match. The next request can be accepted as soon as
// the result is offered, even while the previous result still waits in the output
// register. Slot 0 lives in registers loaded from the host ip and host mac registers;
// the other slots sit in a ram with one valid flip-flop per slot, so no clearing pass
// follows reset. Configuration writes land at once and are meant for when the block
// is idle.
module arp_cache_table_top import arpc_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    arpc_req_if.sink              req,
    arpc_rsp_if.source            rsp
);
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t                state_reg;
    slot_t                 addr_reg;
    slot_t                 cmp_idx_reg;
    logic                  cmp_vld_reg;
    logic                  found_reg;
    slot_t                 hit_idx_reg;
    logic                  free_found_reg;
    slot_t                 free_slot_reg;
    logic [SLOTS-1:0]      valid_reg;
    logic [IP_W-1:0]       host_ip_reg;
    logic [MAC_W-1:0]      slot0_mac_reg;
    logic                  rsp_valid_reg;
    status_t               rsp_status_reg;
    logic [MAC_W-1:0]      rsp_mac_reg;
    logic [SLOT_OUT_W-1:0] rsp_slot_reg;

    op_t                   op_reg;
    logic [IP_W-1:0]       ip_reg;
    logic [MAC_W-1:0]      mac_reg;
    logic [MAC_W-1:0]      hit_mac_reg;

    logic [ENTRY_W-1:0]    ram_rdata;
    logic                  ram_we;
    slot_t                 ram_waddr;

    logic                  ent_static;
    logic [IP_W-1:0]       ent_ip;
    logic [MAC_W-1:0]      ent_mac;
    logic                  ent_valid;
    logic                  scan_last;
    cmp_res_t              cmp_res;

    logic                  out_free;
    status_t               fin_status;
    logic [MAC_W-1:0]      fin_mac;
    slot_t                 fin_slot;
    logic                  fin_ram_we;
    logic                  fin_set_valid;
    logic                  fin_clr_valid;
    logic                  fin_s0_mac_we;

    arpc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({ip_reg, mac_reg}),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    // slot 0 comes from registers, the rest from the ram
    always_comb
    begin
        ent_static = (cmp_idx_reg == '0);
        ent_ip     = ent_static ? host_ip_reg   : ram_rdata[ENTRY_W-1:MAC_W];
        ent_mac    = ent_static ? slot0_mac_reg : ram_rdata[MAC_W-1:0];
        ent_valid  = valid_reg[cmp_idx_reg];
        scan_last  = (cmp_idx_reg == slot_t'(SLOTS - 1));
    end

    arpc_cmp u_cmp (
        .op         (op_reg),
        .req_ip     (ip_reg),
        .req_mac    (mac_reg),
        .ent_ip     (ent_ip),
        .ent_mac    (ent_mac),
        .ent_valid  (ent_valid),
        .ent_static (ent_static),
        .res        (cmp_res)
    );

    // outcome of a finished scan
    always_comb
    begin
        fin_status    = ST_MISS;
        fin_mac       = '0;
        fin_slot      = '0;
        fin_ram_we    = 1'b0;
        fin_set_valid = 1'b0;
        fin_clr_valid = 1'b0;
        fin_s0_mac_we = 1'b0;
        unique case (op_reg)
            OP_LOOKUP:
            begin
                if (found_reg)
                begin
                    fin_status = ST_OK;
                    fin_mac    = hit_mac_reg;
                    fin_slot   = hit_idx_reg;
                end
            end
            OP_INSERT:
            begin
                if (found_reg)
                begin
                    fin_status = ST_PRESENT;
                    fin_slot   = hit_idx_reg;
                end
                else if (free_found_reg)
                begin
                    fin_status    = ST_OK;
                    fin_slot      = free_slot_reg;
                    fin_ram_we    = 1'b1;
                    fin_set_valid = 1'b1;
                end
                else
                begin
                    fin_status = ST_FULL;
                end
            end
            OP_DELETE:
            begin
                if (found_reg)
                begin
                    fin_status    = ST_OK;
                    fin_slot      = hit_idx_reg;
                    fin_clr_valid = 1'b1;
                end
            end
            OP_UPDATE:
            begin
                if (found_reg)
                begin
                    fin_status = ST_OK;
                    fin_slot   = hit_idx_reg;
                    if (hit_idx_reg == '0)
                    begin
                        fin_s0_mac_we = 1'b1;
                    end
                    else
                    begin
                        fin_ram_we = 1'b1;
                    end
                end
            end
        endcase
    end

    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign ram_we    = (state_reg == S_FINISH) && out_free && fin_ram_we;
    assign ram_waddr = fin_slot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= OP_LOOKUP;
            addr_reg       <= '0;
            cmp_idx_reg    <= '0;
            cmp_vld_reg    <= 1'b0;
            found_reg      <= 1'b0;
            hit_idx_reg    <= '0;
            free_found_reg <= 1'b0;
            free_slot_reg  <= '0;
            valid_reg      <= {{(SLOTS-1){1'b0}}, 1'b1};
            host_ip_reg    <= '0;
            slot0_mac_reg  <= '0;
            rsp_valid_reg  <= 1'b0;
            rsp_status_reg <= ST_OK;
            rsp_mac_reg    <= '0;
            rsp_slot_reg   <= '0;
        end
        else
        begin
            if (rsp_valid_reg && rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        state_reg      <= S_SCAN;
                        op_reg         <= req.operation;
                        addr_reg       <= '0;
                        cmp_vld_reg    <= 1'b0;
                        found_reg      <= 1'b0;
                        free_found_reg <= 1'b0;
                    end
                end
                S_SCAN:
                begin
                    // ram read issued at addr_reg, compared in the following cycle
                    addr_reg    <= addr_reg + 1'b1;
                    cmp_idx_reg <= addr_reg;
                    cmp_vld_reg <= 1'b1;
                    if (cmp_vld_reg)
                    begin
                        if (cmp_res.free && !free_found_reg)
                        begin
                            free_found_reg <= 1'b1;
                            free_slot_reg  <= cmp_idx_reg;
                        end
                        if (cmp_res.hit)
                        begin
                            found_reg   <= 1'b1;
                            hit_idx_reg <= cmp_idx_reg;
                            state_reg   <= S_FINISH;
                        end
                        else if (scan_last)
                        begin
                            state_reg <= S_FINISH;
                        end
                    end
                end
                S_FINISH:
                begin
                    if (out_free)
                    begin
                        rsp_valid_reg  <= 1'b1;
                        rsp_status_reg <= fin_status;
                        rsp_mac_reg    <= fin_mac;
                        rsp_slot_reg   <= slot_report(fin_slot);
                        if (fin_set_valid)
                        begin
                            valid_reg[fin_slot] <= 1'b1;
                        end
                        if (fin_clr_valid)
                        begin
                            valid_reg[fin_slot] <= 1'b0;
                        end
                        if (fin_s0_mac_we)
                        begin
                            slot0_mac_reg <= mac_reg;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            if (cfg_we)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_HOST_IP:  host_ip_reg   <= cfg_data[IP_W-1:0];
                    REG_HOST_MAC: slot0_mac_reg <= cfg_data[MAC_W-1:0];
                endcase
            end
        end
    end

    // request and hit payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && req.valid)
        begin
            ip_reg  <= req.ip_addr;
            mac_reg <= req.mac_addr;
        end
        if (state_reg == S_SCAN && cmp_vld_reg && cmp_res.hit)
        begin
            hit_mac_reg <= ent_mac;
        end
    end

    assign req.ready    = (state_reg == S_IDLE);
    assign rsp.valid    = rsp_valid_reg;
    assign rsp.status   = rsp_status_reg;
    assign rsp.mac_out  = rsp_mac_reg;
    assign rsp.slot_out = rsp_slot_reg;
endmodule
